// ----- hw/rtl/mscfp_pkg.sv -----
// shared types and constants of the multiport checksum frame parser
package mscfp_pkg;

  // field widths fixed by the stream format
  localparam int PORT_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int SIDX_W   = 5;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 8;
  localparam int OUT_DW   = 144;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_DEBUG_EN  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_START     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DEBUG_CMD = 3'd2;
  localparam logic [CFG_IW-1:0] REG_ID_MASK   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ACK_MASK  = 3'd4;

  // byte offsets inside a report frame
  localparam int REP_LAST_BYTE = 6;

  // frame size chosen by the second byte
  typedef enum logic [1:0] {
    FSZ_NONE,
    FSZ_REPORT,
    FSZ_DEBUG
  } fsz_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_SEC_RD,
    ST_SEC_CAP,
    ST_REP_RD,
    ST_REP_CAP,
    ST_REP_OUT,
    ST_DBG_RD,
    ST_DBG_CAP,
    ST_DBG_OUT,
    ST_ERR_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take;        // latch the input transaction
    logic step;        // run the per-port frame update
    logic rd_set1;     // point the store read at byte one
    logic rd_inc;      // advance the store read index
    logic cap_second;  // capture the second frame byte
    logic cap_byte;    // shift a payload byte into the assembly register
    logic wr_zero;     // rewrite byte zero on a restarted frame
    logic load_err;    // load an error result
    logic load_rep;    // load a report result
    logic load_smp;    // load a debug sample result
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic good;        // frame finished with a matching checksum
    logic bad;         // frame finished with a checksum mismatch
    logic is_dbg;      // second byte selects a debug frame
    logic rep_done;    // last report byte is being captured
    logic dbg_hi;      // high byte of a sample is being captured
    logic last_sample; // current sample is the final one
    logic slot_free;   // output register can take a result
  } dp_status_t;

endpackage

// ----- hw/rtl/mscfp_ctrl.sv -----
// controller state machine sequencing frame updates, store reads and result loads
module mscfp_ctrl
  import mscfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (status.good) begin
          cmd.rd_set1 = 1'b1;
          state_nxt   = ST_SEC_RD;
        end else if (status.bad) begin
          state_nxt = ST_ERR_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEC_RD: begin
        state_nxt = ST_SEC_CAP;
      end
      ST_SEC_CAP: begin
        cmd.cap_second = 1'b1;
        cmd.rd_inc     = 1'b1;
        state_nxt      = status.is_dbg ? ST_DBG_RD : ST_REP_RD;
      end
      ST_REP_RD: begin
        state_nxt = ST_REP_CAP;
      end
      ST_REP_CAP: begin
        cmd.cap_byte = 1'b1;
        cmd.rd_inc   = 1'b1;
        state_nxt    = status.rep_done ? ST_REP_OUT : ST_REP_RD;
      end
      ST_REP_OUT: begin
        if (status.slot_free) begin
          cmd.load_rep = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_DBG_RD: begin
        state_nxt = ST_DBG_CAP;
      end
      ST_DBG_CAP: begin
        cmd.cap_byte = 1'b1;
        cmd.rd_inc   = 1'b1;
        state_nxt    = status.dbg_hi ? ST_DBG_OUT : ST_DBG_RD;
      end
      ST_DBG_OUT: begin
        if (status.slot_free) begin
          cmd.load_smp = 1'b1;
          state_nxt    = status.last_sample ? ST_IDLE : ST_DBG_RD;
        end
      end
      ST_ERR_OUT: begin
        cmd.wr_zero = 1'b1;
        if (status.slot_free) begin
          cmd.load_err = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/mscfp_dp.sv -----
// datapath: config registers, per-port frame state, frame store and output register
module mscfp_dp
  import mscfp_pkg::*;
#(
  parameter int PORTS       = 4,
  parameter int SAMPLES     = 8,
  parameter int REPORT_SIZE = 8,
  parameter int DEBUG_SIZE  = 19
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PORT_W-1:0] in_port,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [OUT_DW-1:0] out_tdata,
  output logic [KIND_W-1:0] out_tuser,
  output logic              out_tlast
);

  localparam int FRAME_MAX = (REPORT_SIZE > DEBUG_SIZE) ? REPORT_SIZE : DEBUG_SIZE;
  localparam int IW        = $clog2(FRAME_MAX);
  localparam int PW        = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int CW        = $clog2(FRAME_MAX + 1);
  localparam int RD_MAX    = (2 * SAMPLES + 2 > FRAME_MAX + 1) ? 2 * SAMPLES + 2 : FRAME_MAX + 1;
  localparam int RW        = $clog2(RD_MAX);
  localparam int AW        = PW + IW;
  localparam int DEPTH     = 2 ** AW;

  // configuration registers
  logic              debug_en_r;
  logic [BYTE_W-1:0] start_byte_r;
  logic [BYTE_W-1:0] debug_cmd_r;
  logic [BYTE_W-1:0] id_mask_r;
  logic [BYTE_W-1:0] ack_mask_r;
  logic              clear_frames;

  assign clear_frames = cfg_we && (cfg_index == REG_DEBUG_EN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debug_en_r   <= 1'b0;
      start_byte_r <= 8'hA5;
      debug_cmd_r  <= 8'h00;
      id_mask_r    <= 8'h7F;
      ack_mask_r   <= 8'h80;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBUG_EN:  debug_en_r   <= cfg_data[0];
        REG_START:     start_byte_r <= cfg_data;
        REG_DEBUG_CMD: debug_cmd_r  <= cfg_data;
        REG_ID_MASK:   id_mask_r    <= cfg_data;
        REG_ACK_MASK:  ack_mask_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched input transaction
  logic [PORT_W-1:0] port_r;
  logic [BYTE_W-1:0] byte_r;
  logic [PW-1:0]     pidx;
  logic              port_ok;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      port_r <= in_port;
      byte_r <= in_byte;
    end
  end

  assign pidx    = port_r[PW-1:0];
  assign port_ok = ({1'b0, port_r} < (PORT_W + 1)'(PORTS));

  // per-port frame state
  logic [CW-1:0]     count_r [PORTS];
  logic [CW-1:0]     count_nxt [PORTS];
  fsz_t              size_r [PORTS];
  fsz_t              size_nxt [PORTS];
  logic [BYTE_W-1:0] sum_r [PORTS];
  logic [BYTE_W-1:0] sum_nxt [PORTS];
  logic [31:0]       good_r [PORTS];
  logic [31:0]       good_nxt [PORTS];
  logic [31:0]       bad_r [PORTS];
  logic [31:0]       bad_nxt [PORTS];
  logic              restart_r, restart_nxt;

  logic [CW-1:0]     cur_cnt, new_cnt, size_val;
  fsz_t              cur_size, new_size;
  logic [BYTE_W-1:0] cur_sum;
  logic              hunting, start_hit, complete, sum_ok, do_step;

  // frame progress for the latched byte
  always_comb begin
    cur_cnt   = count_r[pidx];
    cur_size  = size_r[pidx];
    cur_sum   = sum_r[pidx];
    hunting   = (cur_cnt == '0);
    start_hit = (byte_r == start_byte_r);
    new_cnt   = cur_cnt + CW'(1);
    if (new_cnt == CW'(2)) begin
      new_size = (debug_en_r && (byte_r == debug_cmd_r)) ? FSZ_DEBUG : FSZ_REPORT;
    end else begin
      new_size = cur_size;
    end
    size_val = (new_size == FSZ_DEBUG) ? CW'(DEBUG_SIZE) : CW'(REPORT_SIZE);
    complete = !hunting && (new_size != FSZ_NONE) && (new_cnt == size_val);
    sum_ok   = (cur_sum == byte_r);
    do_step  = cmd.step && port_ok;
  end

  assign status.good = do_step && complete && sum_ok;
  assign status.bad  = do_step && complete && !sum_ok;

  // next per-port state
  always_comb begin
    count_nxt   = count_r;
    size_nxt    = size_r;
    sum_nxt     = sum_r;
    good_nxt    = good_r;
    bad_nxt     = bad_r;
    restart_nxt = restart_r;
    if (do_step) begin
      restart_nxt = 1'b0;
      if (hunting) begin
        if (start_hit) begin
          count_nxt[pidx] = CW'(1);
          size_nxt[pidx]  = FSZ_NONE;
          sum_nxt[pidx]   = byte_r;
        end
      end else if (complete) begin
        size_nxt[pidx] = FSZ_NONE;
        if (sum_ok) begin
          count_nxt[pidx] = '0;
          good_nxt[pidx]  = good_r[pidx] + 32'd1;
        end else begin
          bad_nxt[pidx] = bad_r[pidx] + 32'd1;
          if (start_hit) begin
            count_nxt[pidx] = CW'(1);
            sum_nxt[pidx]   = byte_r;
            restart_nxt     = 1'b1;
          end else begin
            count_nxt[pidx] = '0;
          end
        end
      end else begin
        count_nxt[pidx] = new_cnt;
        size_nxt[pidx]  = new_size;
        sum_nxt[pidx]   = cur_sum + byte_r;
      end
    end
    // a debug enable write drops every partial frame
    if (clear_frames) begin
      for (int i = 0; i < PORTS; i++) begin
        count_nxt[i] = '0;
        size_nxt[i]  = FSZ_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORTS; i++) begin
        count_r[i] <= '0;
        size_r[i]  <= FSZ_NONE;
        good_r[i]  <= '0;
        bad_r[i]   <= '0;
      end
      restart_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      size_r    <= size_nxt;
      good_r    <= good_nxt;
      bad_r     <= bad_nxt;
      restart_r <= restart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  // frame store, one write and one registered read per cycle
  logic [BYTE_W-1:0] store_mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;
  logic [RW-1:0]     rd_idx_r;
  logic              wr_en;
  logic [IW-1:0]     wr_idx;

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = '0;
    if (do_step && (!hunting || start_hit)) begin
      wr_en  = 1'b1;
      wr_idx = hunting ? '0 : cur_cnt[IW-1:0];
    end else if (cmd.wr_zero && restart_r) begin
      wr_en  = 1'b1;
      wr_idx = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[{pidx, wr_idx}] <= byte_r;
    end
    rdata_r <= store_mem[{pidx, rd_idx_r[IW-1:0]}];
  end

  // read sequencing and byte assembly
  logic [BYTE_W-1:0] rbyte;
  logic [BYTE_W-1:0] second_r;
  logic [39:0]       asm_r;
  logic [SIDX_W-1:0] smp_r;

  assign rbyte = (rd_idx_r >= RW'(FRAME_MAX)) ? '0 : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_set1) begin
      rd_idx_r <= RW'(1);
    end else if (cmd.rd_inc) begin
      rd_idx_r <= rd_idx_r + RW'(1);
    end
    if (cmd.cap_second) begin
      second_r <= rbyte;
    end
    if (cmd.cap_byte) begin
      asm_r <= {rbyte, asm_r[39:8]};
    end
    if (cmd.step) begin
      smp_r <= '0;
    end else if (cmd.load_smp) begin
      smp_r <= smp_r + SIDX_W'(1);
    end
  end

  assign status.is_dbg      = debug_en_r && (rbyte == debug_cmd_r);
  assign status.rep_done    = (rd_idx_r == RW'(REP_LAST_BYTE));
  assign status.dbg_hi      = rd_idx_r[0];
  assign status.last_sample = (smp_r == SIDX_W'(SAMPLES - 1));
  assign status.slot_free   = !out_tvalid || out_tready;

  // output register
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic [KIND_W-1:0] out_kind_r;
  logic              out_last_r;
  logic [BYTE_W-1:0] id_val;
  logic              ack_val;

  assign id_val  = second_r & id_mask_r;
  assign ack_val = |(second_r & ack_mask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_err || cmd.load_rep || cmd.load_smp) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // tdata from bit 0: src_port, armor_id, small_hits, big_hits, epoch, ack_flag,
  // sample_index, sample_value, good_frames, bad_frames, zero fill
  always_ff @(posedge clk) begin
    if (cmd.load_err || cmd.load_rep || cmd.load_smp) begin
      out_data_r          <= '0;
      out_data_r[3:0]     <= port_r;
      out_data_r[105:74]  <= good_r[pidx];
      out_data_r[137:106] <= bad_r[pidx];
      out_last_r          <= 1'b1;
      if (cmd.load_rep) begin
        out_kind_r        <= KIND_REPORT;
        out_data_r[11:4]  <= id_val;
        out_data_r[27:12] <= asm_r[15:0];
        out_data_r[43:28] <= asm_r[31:16];
        out_data_r[51:44] <= asm_r[39:32];
        out_data_r[52]    <= ack_val;
      end else if (cmd.load_smp) begin
        out_kind_r        <= KIND_SAMPLE;
        out_data_r[11:4]  <= BYTE_W'(port_r);
        out_data_r[57:53] <= smp_r;
        out_data_r[73:58] <= asm_r[39:24];
        out_last_r        <= status.last_sample;
      end else begin
        out_kind_r <= KIND_ERROR;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hw/rtl/multiport_sum_checked_frame_parser.sv -----
// top level of the multiport start-byte framed parser with 8-bit additive checksum
//
// Input stream: one received byte per transaction, in_tdata = byte, in_tuser = serial
// port. Each port assembles its own frame starting at the start byte; the second byte
// picks a report frame or a debug sample frame; the last byte is the 8-bit sum check.
// Result stream: one transaction per good report, one per ADC sample of a good debug
// frame, one per checksum error; out_tuser carries the kind, out_tlast the final one.
// Config: cfg_we with cfg_index / cfg_data writes one register; writing debug enable
// drops all partial frames.
// Steps: a byte that finishes no frame is accepted, then runs the frame update. An error
// frame then loads an error result; a report frame reads the second byte and its payload
// bytes from the frame store and loads the report; a debug frame reads each two-byte
// sample and loads one result per sample. No new byte is accepted until the last is loaded.
// Reset clears all frames, counters and the output valid flag and loads register defaults.
// A stalled receiver holds the result in the output register; the parser accepts the
// next byte meanwhile and waits only when it must load a new result.
module multiport_sum_checked_frame_parser
  import mscfp_pkg::*;
#(
  parameter int PORTS       = 4,
  parameter int SAMPLES     = 8,
  parameter int REPORT_SIZE = 8,
  parameter int DEBUG_SIZE  = 19
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // byte_in
  input  logic [PORT_W-1:0] in_tuser,   // port
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // src_port, armor_id, small_hits, big_hits,
                                        // epoch, ack_flag, sample_index, sample_value,
                                        // good_frames, bad_frames, zero fill
  output logic [KIND_W-1:0] out_tuser,  // kind
  output logic              out_tlast,  // last
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mscfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mscfp_dp #(
    .PORTS       (PORTS),
    .SAMPLES     (SAMPLES),
    .REPORT_SIZE (REPORT_SIZE),
    .DEBUG_SIZE  (DEBUG_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_port    (in_tuser),
    .in_byte    (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a result is loaded only into a free output slot
  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_err || cmd.load_rep || cmd.load_smp) |-> status.slot_free)
    else $error("result loaded over a pending result");

  // an accepted byte is processed in the following cycle
  a_step_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> cmd.step)
    else $error("accepted byte not processed");

  // no result load while the input side is open
  a_ready_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.load_err || cmd.load_rep || cmd.load_smp))
    else $error("result load while accepting input");

  // a frame cannot be both good and bad
  a_good_bad: assert property (@(posedge clk) disable iff (!rst_n)
    !(status.good && status.bad))
    else $error("frame both good and bad");

endmodule
